// ===== sv/bmu_pkg.sv =====
// Shared types and constants of the breakpoint match unit.
`default_nettype none
package bmu_pkg;

   localparam int MODE_W   = 2;
   localparam int LINE_IN_W = 16;
   localparam int SLOT_W   = 5;
   localparam int RUN_W    = 2;
   localparam int HITS_W   = 16;

   localparam logic [HITS_W-1:0] HIT_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_CHECK    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CONTINUE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STEP     = 2'd3;

   localparam logic [RUN_W-1:0] RUN_RUNNING  = 2'd0;
   localparam logic [RUN_W-1:0] RUN_PAUSED   = 2'd1;
   localparam logic [RUN_W-1:0] RUN_STEPPING = 2'd2;
   localparam logic [RUN_W-1:0] RUN_STOPPED  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_HIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic hit;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic more;
      logic match;
      logic rd_pending;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/bmu_ctrl.sv =====
// Controller state machine of the breakpoint match unit.
`default_nettype none
module bmu_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  bmu_pkg::status_type  status,
   output bmu_pkg::cmd_type     cmd
);
   import bmu_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.scan_needed ? ST_SCAN : ST_RESP;
         end
         ST_SCAN: begin
            if (status.match) begin
               state_in = ST_HIT;
            end else if (!status.more && !status.rd_pending) begin
               state_in = ST_RESP;
            end
         end
         ST_HIT: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = !status.scan_needed;
         end
         ST_SCAN: begin
            cmd.read = status.more && !status.match;
         end
         ST_HIT: begin
            cmd.hit = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== sv/bmu_datapath.sv =====
// Datapath of the breakpoint match unit: tables, scan pipeline and result registers.
`default_nettype none
module bmu_datapath #(
   parameter int TABLE_DEPTH = 32,
   parameter int LINE_WIDTH  = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  bmu_pkg::cmd_type                     cmd,
   output bmu_pkg::status_type                  status,
   input  wire  [bmu_pkg::MODE_W-1:0]           req_mode,
   input  wire  [bmu_pkg::LINE_IN_W-1:0]        req_line_number,
   output logic                                 rsp_break_now,
   output logic                                 rsp_add_status,
   output logic [bmu_pkg::SLOT_W-1:0]           rsp_added_slot,
   output logic [bmu_pkg::RUN_W-1:0]            rsp_run_state,
   output logic [bmu_pkg::LINE_IN_W-1:0]        rsp_paused_line,
   output logic [bmu_pkg::HITS_W-1:0]           rsp_matched_hits
);
   import bmu_pkg::*;

   localparam int KEEP_W = (LINE_WIDTH < LINE_IN_W) ? LINE_WIDTH : LINE_IN_W;
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // Line table has no reset; the hit counters read as zero until their valid bit is set.
   logic [KEEP_W-1:0] lines_mem [TABLE_DEPTH];
   logic [HITS_W-1:0] hits_mem  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] hvalid_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [RUN_W-1:0]  run_ff;
   logic [KEEP_W-1:0] pause_ff;

   logic [MODE_W-1:0] mode_ff;
   logic [KEEP_W-1:0] line_ff;

   logic [CNT_W-1:0]  scan_addr_ff;
   logic              rd_vld_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [KEEP_W-1:0] rd_line_ff;
   logic [HITS_W-1:0] rd_hit_ff;
   logic              rd_hvalid_ff;

   logic              res_break_ff;
   logic              res_add_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic [HITS_W-1:0] res_hits_ff;

   logic [HITS_W-1:0] hit_cur;
   logic [HITS_W-1:0] hit_new;
   logic              table_full;

   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign hit_cur    = rd_hvalid_ff ? rd_hit_ff : '0;
   assign hit_new    = (hit_cur == HIT_MAX) ? hit_cur : hit_cur + 1'b1;

   assign status.scan_needed = (mode_ff == MODE_CHECK) && (run_ff != RUN_STEPPING);
   assign status.more        = (scan_addr_ff < count_ff);
   assign status.match       = rd_vld_ff && (rd_line_ff == line_ff);
   assign status.rd_pending  = rd_vld_ff;

   // Table reads and writes: during a scan one entry is read per cycle until a match, compared in the next cycle.
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_line_ff   <= lines_mem[scan_addr_ff[IDX_W-1:0]];
         rd_hit_ff    <= hits_mem[scan_addr_ff[IDX_W-1:0]];
         rd_hvalid_ff <= hvalid_ff[scan_addr_ff[IDX_W-1:0]];
         rd_idx_ff    <= scan_addr_ff[IDX_W-1:0];
      end
      if (cmd.exec && mode_ff == MODE_ADD && !table_full) begin
         lines_mem[count_ff[IDX_W-1:0]] <= line_ff;
      end
      if (cmd.hit) begin
         hits_mem[rd_idx_ff] <= hit_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff    <= '0;
         count_ff     <= '0;
         run_ff       <= RUN_STOPPED;
         pause_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         scan_addr_ff <= '0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.capture) begin
            scan_addr_ff <= '0;
         end else if (cmd.read) begin
            scan_addr_ff <= scan_addr_ff + 1'b1;
         end
         if (cmd.exec) begin
            unique case (mode_ff)
               MODE_ADD: begin
                  if (!table_full) count_ff <= count_ff + 1'b1;
               end
               MODE_CONTINUE: run_ff <= RUN_RUNNING;
               MODE_STEP:     run_ff <= RUN_STEPPING;
               default: begin
                  run_ff <= run_ff;
               end
            endcase
         end
         if (cmd.hit) begin
            hvalid_ff[rd_idx_ff] <= 1'b1;
            run_ff               <= RUN_PAUSED;
            pause_ff             <= line_ff;
         end
      end
   end

   // Per-transaction registers and the output register.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff      <= req_mode;
         line_ff      <= req_line_number[KEEP_W-1:0];
         res_break_ff <= 1'b0;
         res_add_ff   <= 1'b0;
         res_slot_ff  <= '0;
         res_hits_ff  <= '0;
      end
      if (cmd.exec) begin
         unique case (mode_ff)
            MODE_CHECK: res_break_ff <= 1'b1;
            MODE_ADD: begin
               if (table_full) begin
                  res_add_ff <= 1'b1;
               end else begin
                  res_slot_ff <= SLOT_W'(count_ff);
               end
            end
            default: begin
               res_break_ff <= 1'b0;
            end
         endcase
      end
      if (cmd.hit) begin
         res_break_ff <= 1'b1;
         res_hits_ff  <= hit_new;
      end
      if (cmd.load_rsp) begin
         rsp_break_now    <= res_break_ff;
         rsp_add_status   <= res_add_ff;
         rsp_added_slot   <= res_slot_ff;
         rsp_run_state    <= run_ff;
         rsp_paused_line  <= LINE_IN_W'(pause_ff);
         rsp_matched_hits <= res_hits_ff;
      end
   end

endmodule
`default_nettype wire

// ===== sv/breakpoint_match_unit.sv =====
// Top level of the breakpoint match unit: controller and datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    mode, line_number
//   rsp_      out        rsp_valid/rsp_ready    break_now, add_status, added_slot,
//                                               run_state, paused_line, matched_hits
//
// Add, continue, single step and a check while stepping go from acceptance
// through the execute and response states to the output register. A check
// scans the line table one entry per cycle through the registered memory
// read until a match is found or the stored entries run out.
// Reset is synchronous and leaves the unit stopped with an empty table.
// One transaction is worked on at a time; a new one is accepted while the
// previous result still waits in the output register.
`default_nettype none
module breakpoint_match_unit #(
   parameter int TABLE_DEPTH = 32,
   parameter int LINE_WIDTH  = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire  [bmu_pkg::MODE_W-1:0]     req_mode,
   input  wire  [bmu_pkg::LINE_IN_W-1:0]  req_line_number,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_break_now,
   output logic                           rsp_add_status,
   output logic [bmu_pkg::SLOT_W-1:0]     rsp_added_slot,
   output logic [bmu_pkg::RUN_W-1:0]      rsp_run_state,
   output logic [bmu_pkg::LINE_IN_W-1:0]  rsp_paused_line,
   output logic [bmu_pkg::HITS_W-1:0]     rsp_matched_hits
);
   import bmu_pkg::*;

   cmd_type    cmd;
   status_type status;

   bmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmu_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LINE_WIDTH  (LINE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_line_number  (req_line_number),
      .rsp_break_now    (rsp_break_now),
      .rsp_add_status   (rsp_add_status),
      .rsp_added_slot   (rsp_added_slot),
      .rsp_run_state    (rsp_run_state),
      .rsp_paused_line  (rsp_paused_line),
      .rsp_matched_hits (rsp_matched_hits)
   );

endmodule
`default_nettype wire

// ===== bench/tb_breakpoint_match_unit.sv =====
// Self-checking testbench for the breakpoint match unit: directed table and random traffic.
module tb_breakpoint_match_unit;
   import bmu_pkg::*;

   localparam int DEPTH       = 32;
   localparam int N_RANDOM    = 1800;
   localparam int LONG_HOLD   = 400;
   localparam int TAIL_CYCLES = 60;
   localparam int N_DIRECTED  = 21;

   typedef struct packed {
      logic                 brk;
      logic                 add_full;
      logic [SLOT_W-1:0]    slot;
      logic [RUN_W-1:0]     run;
      logic [LINE_IN_W-1:0] pline;
      logic [HITS_W-1:0]    hits;
   } bp_result_type;

   typedef struct {
      logic [MODE_W-1:0]    mode;
      logic [LINE_IN_W-1:0] line;
      bit                   typed;
      bp_result_type        exp;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [MODE_W-1:0]    req_mode = MODE_CHECK;
   logic [LINE_IN_W-1:0] req_line_number = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_break_now;
   logic                 rsp_add_status;
   logic [SLOT_W-1:0]    rsp_added_slot;
   logic [RUN_W-1:0]     rsp_run_state;
   logic [LINE_IN_W-1:0] rsp_paused_line;
   logic [HITS_W-1:0]    rsp_matched_hits;

   // Predicted state of the unit.
   logic [LINE_IN_W-1:0] bp_lines [DEPTH];
   logic [HITS_W-1:0]    hit_counts [DEPTH];
   int unsigned          n_entries = 0;
   logic [RUN_W-1:0]     run_st = RUN_STOPPED;
   logic [LINE_IN_W-1:0] pause_line = '0;

   bp_result_type expected_results [$];
   dir_row_type   dir_rows [N_DIRECTED];
   int unsigned   fail_count = 0;
   int unsigned   rsp_count = 0;
   int unsigned   n_sent = 0;
   int unsigned   n_matches = 0;
   int unsigned   n_full = 0;
   int            hold_off_at = -1;

   breakpoint_match_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_line_number  (req_line_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_break_now    (rsp_break_now),
      .rsp_add_status   (rsp_add_status),
      .rsp_added_slot   (rsp_added_slot),
      .rsp_run_state    (rsp_run_state),
      .rsp_paused_line  (rsp_paused_line),
      .rsp_matched_hits (rsp_matched_hits)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      for (int k = 0; k < DEPTH; k++) begin
         bp_lines[k]   = '0;
         hit_counts[k] = '0;
      end
   end

   function automatic bp_result_type predict_breakpoint(logic [MODE_W-1:0] mode,
                                                        logic [LINE_IN_W-1:0] line);
      bp_result_type r;
      bit            found;
      r = '0;
      found = 1'b0;
      case (mode)
         MODE_CHECK: begin
            if (run_st == RUN_STEPPING) begin
               r.brk = 1'b1;
            end else begin
               for (int idx = 0; idx < n_entries && !found; idx++) begin
                  if (bp_lines[idx] == line) begin
                     found = 1'b1;
                     if (hit_counts[idx] != HIT_MAX) hit_counts[idx]++;
                     r.hits     = hit_counts[idx];
                     r.brk      = 1'b1;
                     run_st     = RUN_PAUSED;
                     pause_line = line;
                  end
               end
            end
         end
         MODE_ADD: begin
            if (n_entries >= DEPTH) begin
               r.add_full = 1'b1;
            end else begin
               bp_lines[n_entries] = line;
               r.slot = n_entries[SLOT_W-1:0];
               n_entries++;
            end
         end
         MODE_CONTINUE: run_st = RUN_RUNNING;
         MODE_STEP:     run_st = RUN_STEPPING;
      endcase
      r.run   = run_st;
      r.pline = pause_line;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      end
   endfunction

   task automatic check_result(bp_result_type act);
      bp_result_type exp;
      if (expected_results.size() == 0) begin
         fail_count++;
         $display("%0t: result with no transaction pending, expected none, actual %h",
                  $time, act);
         return;
      end
      exp = expected_results.pop_front();
      check_field("break_now",    exp.brk,      act.brk);
      check_field("add_status",   exp.add_full, act.add_full);
      check_field("added_slot",   exp.slot,     act.slot);
      check_field("run_state",    exp.run,      act.run);
      check_field("paused_line",  exp.pline,    act.pline);
      check_field("matched_hits", exp.hits,     act.hits);
   endtask

   // Offers one transaction and waits for it to be taken; valid stays high afterwards.
   task automatic send_txn(logic [MODE_W-1:0] mode, logic [LINE_IN_W-1:0] line,
                           bit typed, bp_result_type typed_exp);
      bp_result_type pred;
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_line_number <= line;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = predict_breakpoint(mode, line);
      if (pred.brk && pred.hits != 0) n_matches++;
      if (pred.add_full) n_full++;
      expected_results.push_back(typed ? typed_exp : pred);
      n_sent++;
   endtask

   task automatic idle_cycles(int unsigned n);
      req_valid       <= 1'b0;
      req_mode        <= MODE_W'($urandom);
      req_line_number <= LINE_IN_W'($urandom);
      repeat (n) @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Receiver: checks results and throttles rsp_ready in its own pattern.
   initial begin : receiver
      int unsigned rx_style;
      int unsigned style_left;
      bit          long_hold_done;
      rx_style = 0;
      style_left = 0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
            check_result({rsp_break_now, rsp_add_status, rsp_added_slot, rsp_run_state,
                          rsp_paused_line, rsp_matched_hits});
            rsp_count++;
         end
         if (style_left == 0) begin
            rx_style   = $urandom_range(0, 2);
            style_left = $urandom_range(20, 80);
         end
         style_left--;
         if (!long_hold_done && hold_off_at >= 0 && rsp_count >= hold_off_at) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (rx_style == 0) begin
            rsp_ready <= 1'b1;
         end else if (rx_style == 1) begin
            rsp_ready <= ($urandom_range(0, 1) == 1);
         end else begin
            rsp_ready <= ($urandom_range(0, 4) == 0);
         end
      end
   end

   initial begin : stimulus
      int unsigned        burst;
      int unsigned        n_rand;
      int unsigned        next_drain;
      int unsigned        pick;
      logic [MODE_W-1:0]  m;
      logic [LINE_IN_W-1:0] ln;

      // Typed expectations follow directly from reset state; the rest use the predictor.
      dir_rows = '{
         '{MODE_CHECK,    16'h0000, 1'b1, {1'b0, 1'b0, 5'd0, RUN_STOPPED, 16'h0000, 16'd0}},
         '{MODE_ADD,      16'h1234, 1'b1, {1'b0, 1'b0, 5'd0, RUN_STOPPED, 16'h0000, 16'd0}},
         '{MODE_ADD,      16'hFFFF, 1'b1, {1'b0, 1'b0, 5'd1, RUN_STOPPED, 16'h0000, 16'd0}},
         '{MODE_CHECK,    16'h5555, 1'b1, {1'b0, 1'b0, 5'd0, RUN_STOPPED, 16'h0000, 16'd0}},
         '{MODE_CHECK,    16'hFFFF, 1'b1, {1'b1, 1'b0, 5'd0, RUN_PAUSED,  16'hFFFF, 16'd1}},
         '{MODE_ADD,      16'h0000, 1'b1, {1'b0, 1'b0, 5'd2, RUN_PAUSED,  16'hFFFF, 16'd0}},
         '{MODE_ADD,      16'h1234, 1'b1, {1'b0, 1'b0, 5'd3, RUN_PAUSED,  16'hFFFF, 16'd0}},
         '{MODE_CHECK,    16'h1234, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h1234, 1'b0, bp_result_type'('0)},
         '{MODE_CONTINUE, 16'h0000, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h0000, 1'b0, bp_result_type'('0)},
         '{MODE_STEP,     16'hFFFF, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h1234, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h9999, 1'b0, bp_result_type'('0)},
         '{MODE_ADD,      16'hAAAA, 1'b0, bp_result_type'('0)},
         '{MODE_STEP,     16'h8000, 1'b0, bp_result_type'('0)},
         '{MODE_CONTINUE, 16'h7FFF, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h7FFF, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'hAAAA, 1'b0, bp_result_type'('0)},
         '{MODE_CONTINUE, 16'h5555, 1'b0, bp_result_type'('0)},
         '{MODE_CHECK,    16'h1234, 1'b0, bp_result_type'('0)}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         send_txn(dir_rows[r].mode, dir_rows[r].line, dir_rows[r].typed, dir_rows[r].exp);
         if ($urandom_range(0, 1) == 1) idle_cycles($urandom_range(1, 4));
      end
      pause_until_drained();

      hold_off_at = rsp_count + 100;
      n_rand = 0;
      next_drain = 450;
      while (n_rand < N_RANDOM) begin
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst && n_rand < N_RANDOM; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      m = MODE_CHECK;
            else if (pick < 70) m = MODE_ADD;
            else if (pick < 85) m = MODE_CONTINUE;
            else                m = MODE_STEP;
            // Most lines repeat a stored breakpoint so checks usually find a match.
            if (n_entries > 0 && $urandom_range(0, 9) < 7)
               ln = bp_lines[$urandom_range(0, n_entries - 1)];
            else
               ln = LINE_IN_W'($urandom);
            send_txn(m, ln, 1'b0, '0);
            n_rand++;
         end
         if (n_rand >= next_drain) begin
            pause_until_drained();
            next_drain += 450;
         end else if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 20));
         end
      end

      pause_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Ran %0d transactions (%0d results checked), %0d breakpoint matches,",
               n_sent, rsp_count, n_matches);
      $display("%0d adds refused on a full table, one receiver hold-off of %0d cycles.",
               n_full, LONG_HOLD);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("breakpoint_match_unit test passed");
      end else begin
         $display("breakpoint_match_unit test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(8 * 6000000);
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("breakpoint_match_unit test failed");
      $finish;
   end

endmodule
